// ===== hdl/wra_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package wra_pkg;

  localparam int GRID_SIDE = 16;
  localparam int CELLS = GRID_SIDE * GRID_SIDE;
  localparam int CELL_W = $clog2(CELLS);
  localparam int ROW_W = $clog2(GRID_SIDE);
  localparam int STEP_W = $clog2(GRID_SIDE + 2);
  localparam int STEP_LAST = GRID_SIDE + 1;

  localparam int Q_W = 24;
  localparam int SUM_W = Q_W + 2;
  localparam int Q_MAX = 2 ** (Q_W - 1) - 1;
  localparam int Q_MIN = -(2 ** (Q_W - 1));
  localparam int Q_ONE = 65536;
  localparam int DRIVE_DROP = 19661;
  localparam int DRIVE_SPARK = 32768;
  localparam int ACC_W = 32;

  localparam int DIV_W = 28;
  localparam int DIV_SH = 30;
  localparam int DIV_MW = 28;
  localparam int DIV_M = (2 ** DIV_SH) / 5;
  localparam int DIV_BIAS = 5 * (2 ** (DIV_W - 1));
  localparam int DIV_LAT = 3;

  localparam int SPARK_BITS = 256;
  localparam int PIX_W = 8;
  localparam int MOD_SH = 16;
  localparam int MOD_RW = 17;
  localparam int MOD_RECIP = (2 ** MOD_SH) / CELLS;
  localparam int MOD_PW = PIX_W + MOD_RW;
  localparam int MOD_QW = MOD_PW - MOD_SH;

  localparam int LVL_CLAMP_W = 17;
  localparam int SQ_W = 2 * LVL_CLAMP_W;
  localparam int BP_W = SQ_W + 6;
  localparam int RED_W = 7;
  localparam int GREEN_W = 7;
  localparam int BLUE_W = 8;
  localparam int RED_BASE = 32;
  localparam int GREEN_BASE = 50;
  localparam int BLUE_BASE = 146;
  localparam int BLUE_SCALE = 50;
  localparam int RED_SH = 27;
  localparam int GREEN_SH = 26;
  localparam int BLUE_SH = 32;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef logic signed [Q_W-1:0] q_t;
  typedef logic signed [DIV_W-1:0] div_t;
  typedef logic [CELL_W-1:0] cell_t;
  typedef logic [CELL_W:0] cellx_t;
  typedef logic [ROW_W-1:0] row_t;
  typedef logic [STEP_W-1:0] step_t;

  typedef struct packed {
    logic  bank;
    cell_t idx;
  } lvl_addr_t;

  typedef struct packed {
    logic      en;
    lvl_addr_t addr;
    q_t        data;
  } lvl_wr_t;

  typedef struct packed {
    q_t heat;
    q_t drive;
  } hd_t;

  typedef struct packed {
    logic  en;
    cell_t idx;
    hd_t   data;
  } hd_wr_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_TICK,
    ST_RD_MOD,
    ST_RD_ADDR,
    ST_RD_DATA,
    ST_RD_COLOR
  } state_e;

  function automatic q_t sat_q(input div_t v);
    q_t r;
    if (v > Q_MAX) begin
      r = q_t'(Q_MAX);
    end else if (v < Q_MIN) begin
      r = q_t'(Q_MIN);
    end else begin
      r = q_t'(v);
    end
    return r;
  endfunction

  function automatic logic [7:0] spark_idx(input cell_t c);
    logic [CELL_W+7:0] w;
    w = {8'b0, c};
    return w[7:0];
  endfunction

endpackage
`default_nettype wire

// ===== hdl/wra_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface wra_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [63:0] spark_bits_0;
  logic [63:0] spark_bits_1;
  logic [63:0] spark_bits_2;
  logic [63:0] spark_bits_3;
  logic [7:0]  pixel_index;

  modport source (
    output valid, command, spark_bits_0, spark_bits_1, spark_bits_2, spark_bits_3,
           pixel_index,
    input  ready
  );

  modport sink (
    input  valid, command, spark_bits_0, spark_bits_1, spark_bits_2, spark_bits_3,
           pixel_index,
    output ready
  );
endinterface
`default_nettype wire

// ===== hdl/wra_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface wra_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] red;
  logic [6:0] green;
  logic [7:0] blue;

  modport source (
    output valid, red, green, blue,
    input  ready
  );

  modport sink (
    input  valid, red, green, blue,
    output ready
  );
endinterface
`default_nettype wire

// ===== hdl/wra_fdiv5.sv =====
`timescale 1ns / 1ps
`default_nettype none
module wra_fdiv5 import wra_pkg::*; (
  input  logic clk_i,
  input  div_t x_i,
  output div_t q_o
);

  logic [DIV_SH:0]          xs;
  logic [DIV_SH-1:0]        xb_q;
  logic [DIV_SH-1:0]        xb2_q;
  logic [DIV_SH+DIV_MW-1:0] prod;
  logic [DIV_MW-1:0]        q0_q;
  logic [DIV_SH-1:0]        rem;
  logic [DIV_MW-1:0]        q1;
  div_t                     res_q;

  // The operand is biased to a positive value so that the reciprocal
  // estimate truncates in the same direction as a floor division.
  assign xs = (DIV_SH + 1)'(x_i) + (DIV_SH + 1)'(DIV_BIAS);
  assign prod = (DIV_SH + DIV_MW)'(xb_q) * (DIV_SH + DIV_MW)'(DIV_M);
  assign rem = xb2_q - (DIV_SH'(q0_q) << 2) - DIV_SH'(q0_q);
  assign q1 = (rem >= DIV_SH'(5)) ? q0_q + DIV_MW'(1) : q0_q;

  always_ff @(posedge clk_i) begin
    xb_q  <= xs[DIV_SH-1:0];
    xb2_q <= xb_q;
    q0_q  <= prod[DIV_SH+DIV_MW-1:DIV_SH];
    res_q <= div_t'(q1 - DIV_MW'(2 ** (DIV_W - 1)));
  end

  assign q_o = res_q;

endmodule
`default_nettype wire

// ===== hdl/wra_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
module wra_store import wra_pkg::*; (
  input  logic      clk_i,
  input  lvl_addr_t lvl_raddr_i,
  input  lvl_wr_t   lvl_wr_i,
  input  cell_t     hd_raddr_i,
  input  hd_wr_t    hd_wr_i,
  output q_t        lvl_rdata_o,
  output hd_t       hd_rdata_o
);

  q_t  level_mem [2][CELLS];
  hd_t hd_mem [CELLS];
  q_t  lvl_rdata_q;
  hd_t hd_rdata_q;

  always_ff @(posedge clk_i) begin
    if (lvl_wr_i.en) begin
      level_mem[lvl_wr_i.addr.bank][lvl_wr_i.addr.idx] <= lvl_wr_i.data;
    end
    lvl_rdata_q <= level_mem[lvl_raddr_i.bank][lvl_raddr_i.idx];
  end

  always_ff @(posedge clk_i) begin
    if (hd_wr_i.en) begin
      hd_mem[hd_wr_i.idx] <= hd_wr_i.data;
    end
    hd_rdata_q <= hd_mem[hd_raddr_i];
  end

  assign lvl_rdata_o = lvl_rdata_q;
  assign hd_rdata_o  = hd_rdata_q;

endmodule
`default_nettype wire

// ===== hdl/wra_update.sv =====
`timescale 1ns / 1ps
`default_nettype none
module wra_update import wra_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  bank_i,
  input  logic [SPARK_BITS-1:0] spark_i,
  input  q_t                    lvl_rdata_i,
  input  hd_t                   hd_rdata_i,
  output lvl_addr_t             lvl_raddr_o,
  output cell_t                 hd_raddr_o,
  output lvl_wr_t               lvl_wr_o,
  output hd_wr_t                hd_wr_o,
  output logic                  done_o
);

  typedef struct packed {
    logic  last;
    cell_t idx;
    q_t    drive;
  } meta_t;

  logic  run_q;
  row_t  col_q;
  step_t step_q;
  row_t  row;
  cell_t issue_cell;
  logic  issue_last;

  logic  p1_v_q, p1_c_q, p1_last_q;
  cell_t p1_cell_q;
  q_t    w0_q, w1_q;
  logic signed [SUM_W-1:0] sum;

  logic  p2_v_q, p2_last_q, p2_spark_q;
  cell_t p2_cell_q;
  logic signed [SUM_W-1:0] p2_sum_q;
  q_t    p2_heat_q, p2_drive_q;

  logic signed [ACC_W-1:0] lvl_acc, heat_acc;
  div_t  lvl_x, heat_x, lvl_q, heat_q;
  q_t    drive_next;
  q_t    heat_sat;

  logic  mv_q [DIV_LAT];
  meta_t meta_q [DIV_LAT];

  // Each column is walked from the two wrapped rows above row zero down to
  // the last row, so two registers hold the older rows of the window.
  assign row = (step_q < step_t'(2)) ? row_t'(GRID_SIDE - 2 + int'(step_q))
                                     : row_t'(step_q - step_t'(2));
  assign issue_cell = cell_t'(cell_t'(row) * cell_t'(GRID_SIDE)) + cell_t'(col_q);
  assign issue_last = (col_q == row_t'(GRID_SIDE - 1)) && (step_q == step_t'(STEP_LAST));

  assign lvl_raddr_o = '{bank: bank_i, idx: issue_cell};
  assign hd_raddr_o  = issue_cell;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      col_q  <= '0;
      step_q <= '0;
      p1_v_q <= 1'b0;
      p2_v_q <= 1'b0;
      for (int i = 0; i < DIV_LAT; i++) begin
        mv_q[i] <= 1'b0;
      end
    end else begin
      if (start_i) begin
        run_q  <= 1'b1;
        col_q  <= '0;
        step_q <= '0;
      end else if (run_q) begin
        if (step_q == step_t'(STEP_LAST)) begin
          step_q <= '0;
          col_q  <= col_q + row_t'(1);
          if (issue_last) begin
            run_q <= 1'b0;
          end
        end else begin
          step_q <= step_q + step_t'(1);
        end
      end
      p1_v_q <= run_q;
      p2_v_q <= p1_v_q && p1_c_q;
      mv_q[0] <= p2_v_q;
      for (int i = 1; i < DIV_LAT; i++) begin
        mv_q[i] <= mv_q[i-1];
      end
    end
  end

  assign sum = SUM_W'(w1_q) + SUM_W'(w0_q) + SUM_W'(lvl_rdata_i);

  always_ff @(posedge clk_i) begin
    p1_c_q    <= step_q >= step_t'(2);
    p1_last_q <= issue_last;
    p1_cell_q <= issue_cell;
    if (p1_v_q) begin
      w1_q <= w0_q;
      w0_q <= lvl_rdata_i;
    end
    p2_sum_q   <= sum;
    p2_heat_q  <= hd_rdata_i.heat;
    p2_drive_q <= hd_rdata_i.drive;
    p2_spark_q <= spark_i[spark_idx(p1_cell_q)];
    p2_cell_q  <= p1_cell_q;
    p2_last_q  <= p1_last_q;
  end

  // Division by 80 is a floor shift by four followed by a floor division by
  // five; division by 20 is a shift by two followed by the same.
  assign lvl_acc = ACC_W'(32'sd25) * ACC_W'(p2_sum_q) + ACC_W'(32'sd64) * ACC_W'(p2_heat_q)
                 + ACC_W'(32'sd40);
  assign heat_acc = ACC_W'(32'sd20) * ACC_W'(p2_heat_q) + ACC_W'(p2_drive_q)
                  + ACC_W'(32'sd10);
  assign lvl_x  = div_t'(lvl_acc >>> 4);
  assign heat_x = div_t'(heat_acc >>> 2);
  assign drive_next = p2_spark_q ? q_t'(DRIVE_SPARK)
                                 : sat_q(div_t'(p2_drive_q) - div_t'(DRIVE_DROP));

  wra_fdiv5 u_div_lvl (
    .clk_i (clk_i),
    .x_i   (lvl_x),
    .q_o   (lvl_q)
  );

  wra_fdiv5 u_div_heat (
    .clk_i (clk_i),
    .x_i   (heat_x),
    .q_o   (heat_q)
  );

  always_ff @(posedge clk_i) begin
    meta_q[0] <= '{last: p2_last_q, idx: p2_cell_q, drive: drive_next};
    for (int i = 1; i < DIV_LAT; i++) begin
      meta_q[i] <= meta_q[i-1];
    end
  end

  assign heat_sat = sat_q(heat_q);

  assign lvl_wr_o = '{en: mv_q[DIV_LAT-1],
                      addr: '{bank: ~bank_i, idx: meta_q[DIV_LAT-1].idx},
                      data: sat_q(lvl_q)};
  assign hd_wr_o = '{en: mv_q[DIV_LAT-1],
                     idx: meta_q[DIV_LAT-1].idx,
                     data: '{heat: (heat_sat < 0) ? q_t'(0) : heat_sat,
                             drive: meta_q[DIV_LAT-1].drive}};
  assign done_o = mv_q[DIV_LAT-1] && meta_q[DIV_LAT-1].last;

endmodule
`default_nettype wire

// ===== hdl/water_ripple_texture_animator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// After reset the block clears the heat and drive memory and bank zero of the level memory,
// one cell a cycle, and accepts no item while it does so.
// A tick item walks each column through the single read port of the level memory, starting
// with the two wrapped rows above row zero.
// A read item steps through ST_RD_MOD, ST_RD_ADDR, ST_RD_DATA and ST_RD_COLOR, which waits
// for the output register to be free; no new item is taken until its result is loaded.
module water_ripple_texture_animator import wra_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  wra_in_if.sink    in_i,
  wra_out_if.source out_o
);

  state_e state_q, state_d;
  cell_t  clr_q;
  logic [3:0] tick_q;
  cell_t  shift_q;
  logic   bank_q;

  logic [SPARK_BITS-1:0] spark_q;
  logic [PIX_W-1:0]      pix_q;
  logic [MOD_QW-1:0]     q0_q;
  logic [SQ_W-1:0]       sq_q;
  logic                  out_valid_q;
  logic [RED_W-1:0]      red_q;
  logic [GREEN_W-1:0]    green_q;
  logic [BLUE_W-1:0]     blue_q;

  logic in_acc, tick_start, rd_start, out_load, upd_done;
  lvl_addr_t upd_lvl_raddr, lvl_raddr;
  cell_t     upd_hd_raddr;
  lvl_wr_t   upd_lvl_wr, lvl_wr;
  hd_wr_t    upd_hd_wr, hd_wr;
  q_t        lvl_rdata;
  hd_t       hd_rdata;

  logic [MOD_PW-1:0]      mprod;
  logic [PIX_W:0]         rx;
  cell_t                  pcell, rd_cell;
  cellx_t                 shift_sum;
  cell_t                  shift_next;
  logic [LVL_CLAMP_W-1:0] lvl_clamp;
  logic [BP_W-1:0]        blue_prod;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign tick_start = in_acc && (in_i.command == CMD_TICK);
  assign rd_start   = in_acc && (in_i.command == CMD_READ);

  always_comb begin
    state_d  = state_q;
    out_load = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_q == cell_t'(CELLS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (tick_start) begin
          state_d = ST_TICK;
        end else if (rd_start) begin
          state_d = ST_RD_MOD;
        end
      end
      ST_TICK: begin
        if (upd_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_RD_MOD:  state_d = ST_RD_ADDR;
      ST_RD_ADDR: state_d = ST_RD_DATA;
      ST_RD_DATA: state_d = ST_RD_COLOR;
      ST_RD_COLOR: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // The pixel index is reduced modulo the cell count through a reciprocal
  // estimate and one correction, then moved back by the row shift.
  assign mprod = MOD_PW'(pix_q) * MOD_PW'(MOD_RECIP);

  always_comb begin
    rx = {1'b0, pix_q} - (PIX_W + 1)'(q0_q * CELLS);
    if (rx >= CELLS) begin
      rx = rx - (PIX_W + 1)'(CELLS);
    end
    pcell = cell_t'(rx);
    if (pcell >= shift_q) begin
      rd_cell = pcell - shift_q;
    end else begin
      rd_cell = cell_t'(cellx_t'(pcell) + cellx_t'(CELLS) - cellx_t'(shift_q));
    end
  end

  always_comb begin
    shift_sum = cellx_t'(shift_q) + cellx_t'(GRID_SIDE);
    if (shift_sum >= CELLS) begin
      shift_sum = shift_sum - cellx_t'(CELLS);
    end
    shift_next = (tick_q == 4'd15) ? '0 : cell_t'(shift_sum);
  end

  always_comb begin
    if (lvl_rdata < 0) begin
      lvl_clamp = '0;
    end else if (lvl_rdata > Q_ONE) begin
      lvl_clamp = LVL_CLAMP_W'(Q_ONE);
    end else begin
      lvl_clamp = LVL_CLAMP_W'(lvl_rdata);
    end
  end

  assign blue_prod = BP_W'(sq_q) * BP_W'(BLUE_SCALE);

  always_comb begin
    lvl_raddr = (state_q == ST_TICK) ? upd_lvl_raddr : lvl_addr_t'{bank: bank_q, idx: rd_cell};
    if (state_q == ST_CLEAR) begin
      lvl_wr = '{en: 1'b1, addr: '{bank: 1'b0, idx: clr_q}, data: '0};
      hd_wr  = '{en: 1'b1, idx: clr_q, data: '0};
    end else begin
      lvl_wr = upd_lvl_wr;
      hd_wr  = upd_hd_wr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      tick_q      <= '0;
      shift_q     <= '0;
      bank_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + cell_t'(1);
      end
      if ((state_q == ST_TICK) && upd_done) begin
        tick_q  <= tick_q + 4'd1;
        shift_q <= shift_next;
        bank_q  <= ~bank_q;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_start) begin
      spark_q <= {in_i.spark_bits_3, in_i.spark_bits_2, in_i.spark_bits_1, in_i.spark_bits_0};
    end
    if (rd_start) begin
      pix_q <= in_i.pixel_index;
    end
    q0_q <= mprod[MOD_PW-1:MOD_SH];
    sq_q <= SQ_W'(lvl_clamp) * SQ_W'(lvl_clamp);
    if (out_load) begin
      red_q   <= RED_W'(RED_BASE + (sq_q >> RED_SH));
      green_q <= GREEN_W'(GREEN_BASE + (sq_q >> GREEN_SH));
      blue_q  <= BLUE_W'(BLUE_BASE + (blue_prod >> BLUE_SH));
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.red   = red_q;
  assign out_o.green = green_q;
  assign out_o.blue  = blue_q;

  wra_update u_update (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (tick_start),
    .bank_i      (bank_q),
    .spark_i     (spark_q),
    .lvl_rdata_i (lvl_rdata),
    .hd_rdata_i  (hd_rdata),
    .lvl_raddr_o (upd_lvl_raddr),
    .hd_raddr_o  (upd_hd_raddr),
    .lvl_wr_o    (upd_lvl_wr),
    .hd_wr_o     (upd_hd_wr),
    .done_o      (upd_done)
  );

  wra_store u_store (
    .clk_i       (clk_i),
    .lvl_raddr_i (lvl_raddr),
    .lvl_wr_i    (lvl_wr),
    .hd_raddr_i  (upd_hd_raddr),
    .hd_wr_i     (hd_wr),
    .lvl_rdata_o (lvl_rdata),
    .hd_rdata_o  (hd_rdata)
  );

`ifndef NO_ASSERTIONS
  a_done_in_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_done |-> (state_q == ST_TICK))
    else $error("tick update finished outside a tick");

  a_write_other_bank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upd_lvl_wr.en && (state_q == ST_TICK)) |-> (upd_lvl_wr.addr.bank != bank_q))
    else $error("tick update writes the level bank that it reads");

  a_read_cell_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RD_ADDR) |-> (rd_cell < CELLS))
    else $error("pixel read addresses a cell beyond the grid");

  a_color_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((red_q >= 7'd32) && (red_q <= 7'd64)
                     && (green_q >= 7'd50) && (green_q <= 7'd114)
                     && (blue_q >= 8'd146) && (blue_q <= 8'd196)))
    else $error("pixel color outside its range");

  a_no_item_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> (!in_acc && !upd_lvl_wr.en))
    else $error("item taken or update active during the clearing pass");
`endif

endmodule
`default_nettype wire

// ===== test/water_ripple_texture_animator_test.sv =====
`timescale 1ns / 1ps
module water_ripple_texture_animator_test;
  import wra_pkg::*;

  localparam int IDLE_MAX = 12;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int STALL_LIMIT = 4000;
  localparam int END_SETTLE = 400;
  localparam int REPORT_MAX = 10;
  localparam int RANDOM_ITEMS = 300;
  localparam int FLOOD_TICKS = 480;
  localparam int DRAIN_TICKS = 440;

  typedef struct packed {
    logic [RED_W-1:0]   red;
    logic [GREEN_W-1:0] green;
    logic [BLUE_W-1:0]  blue;
  } pixel_rgb_t;

  typedef enum int unsigned {
    SPARK_NONE,
    SPARK_ALL,
    SPARK_SPARSE,
    SPARK_DENSE,
    SPARK_RANDOM
  } spark_mix_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  wra_in_if  in_bus ();
  wra_out_if out_bus ();

  water_ripple_texture_animator i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus.sink),
    .out_o  (out_bus.source)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  q_t level_q[CELLS] = '{default: '0};
  q_t heat_q[CELLS] = '{default: '0};
  q_t drive_q[CELLS] = '{default: '0};
  logic [3:0] frame_count = '0;

  pixel_rgb_t pending_colors[$];

  int sender_idle_max = IDLE_MAX;
  int receiver_idle_max = IDLE_MAX;
  logic hold_request = 1'b0;
  int quiet_cycles = 0;

  int ticks_sent = 0;
  int reads_sent = 0;
  int colors_checked = 0;
  int mismatches = 0;
  int stray_results = 0;
  int hold_offs = 0;
  int frame_wraps = 0;
  bit level_ceiling_seen = 1'b0;
  bit drive_floor_seen = 1'b0;
  int failures;

  function automatic longint div_floor(input longint num, input longint den);
    longint quo;
    quo = num / den;
    if ((num % den) != 0 && num < 0) begin
      quo = quo - 1;
    end
    return quo;
  endfunction

  function automatic q_t clamp_q(input longint v);
    if (v > Q_MAX) begin
      return q_t'(Q_MAX);
    end
    if (v < Q_MIN) begin
      return q_t'(Q_MIN);
    end
    return q_t'(v);
  endfunction

  task automatic advance_ripple(input logic [SPARK_BITS-1:0] sparks);
    q_t fresh[CELLS];
    longint col_sum;
    longint warm;
    int spot;
    frame_count = frame_count + 1'b1;
    if (frame_count == 0) begin
      frame_wraps++;
    end
    for (int r = 0; r < GRID_SIDE; r++) begin
      for (int c = 0; c < GRID_SIDE; c++) begin
        col_sum = 0;
        for (int k = 0; k < 3; k++) begin
          col_sum += level_q[((r + GRID_SIDE - 2 + k) % GRID_SIDE) * GRID_SIDE + c];
        end
        spot = r * GRID_SIDE + c;
        fresh[spot] = clamp_q(div_floor(25 * col_sum + 64 * longint'(heat_q[spot]) + 40, 80));
        if (fresh[spot] == q_t'(Q_MAX)) begin
          level_ceiling_seen = 1'b1;
        end
      end
    end
    for (int k = 0; k < CELLS; k++) begin
      warm = div_floor(20 * longint'(heat_q[k]) + longint'(drive_q[k]) + 10, 20);
      heat_q[k] = (warm < 0) ? q_t'(0) : clamp_q(warm);
      if (sparks[k % SPARK_BITS]) begin
        drive_q[k] = q_t'(DRIVE_SPARK);
      end else begin
        drive_q[k] = clamp_q(longint'(drive_q[k]) - DRIVE_DROP);
      end
      if (drive_q[k] == q_t'(Q_MIN)) begin
        drive_floor_seen = 1'b1;
      end
    end
    level_q = fresh;
  endtask

  function automatic pixel_rgb_t pixel_color(input logic [PIX_W-1:0] pix);
    int spot;
    longint lv;
    logic [63:0] sq;
    pixel_rgb_t rgb;
    spot = (int'(pix) % CELLS + CELLS - (GRID_SIDE * int'(frame_count)) % CELLS) % CELLS;
    lv = level_q[spot];
    if (lv > Q_ONE) begin
      lv = Q_ONE;
    end
    if (lv < 0) begin
      lv = 0;
    end
    sq = lv * lv;
    rgb.red = RED_W'(RED_BASE + ((64'd32 * sq) >> 32));
    rgb.green = GREEN_W'(GREEN_BASE + ((64'd64 * sq) >> 32));
    rgb.blue = BLUE_W'(BLUE_BASE + ((64'd50 * sq) >> 32));
    return rgb;
  endfunction

  function automatic logic [SPARK_BITS-1:0] random_bits();
    logic [SPARK_BITS-1:0] bits;
    for (int w = 0; w < SPARK_BITS / 32; w++) begin
      bits[w*32 +: 32] = $urandom();
    end
    return bits;
  endfunction

  function automatic logic [SPARK_BITS-1:0] draw_sparks(input spark_mix_e mix);
    logic [SPARK_BITS-1:0] bits;
    bits = random_bits();
    case (mix)
      SPARK_NONE: begin
        bits = '0;
      end
      SPARK_ALL: begin
        bits = '1;
      end
      SPARK_SPARSE: begin
        bits = bits & random_bits() & random_bits();
      end
      SPARK_DENSE: begin
        bits = bits | random_bits() | random_bits();
      end
      default: begin
      end
    endcase
    return bits;
  endfunction

  task automatic offer_item(input logic cmd, input logic [SPARK_BITS-1:0] sparks,
                            input logic [PIX_W-1:0] pix);
    int unsigned gap;
    gap = $urandom_range(0, sender_idle_max);
    if (gap != 0) begin
      in_bus.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_bus.valid = 1'b1;
    in_bus.command = cmd;
    in_bus.spark_bits_0 = sparks[63:0];
    in_bus.spark_bits_1 = sparks[127:64];
    in_bus.spark_bits_2 = sparks[191:128];
    in_bus.spark_bits_3 = sparks[255:192];
    in_bus.pixel_index = pix;
    do @(posedge clk_i); while (!in_bus.ready);
    if (cmd == CMD_TICK) begin
      advance_ripple(sparks);
      ticks_sent++;
    end else begin
      pending_colors.push_back(pixel_color(pix));
      reads_sent++;
    end
    @(negedge clk_i);
  endtask

  task automatic offer_tick(input logic [SPARK_BITS-1:0] sparks);
    offer_item(CMD_TICK, sparks, PIX_W'($urandom_range(0, 255)));
  endtask

  task automatic offer_read(input logic [PIX_W-1:0] pix);
    offer_item(CMD_READ, random_bits(), pix);
  endtask

  // Sixteen ticks in all, so the frame counter wraps back to zero.
  task automatic test_directed_corners();
    offer_read(8'd0);
    offer_read(8'd255);
    repeat (3) offer_tick('1);
    offer_read(8'd0);
    offer_read(8'd255);
    offer_tick('0);
    offer_tick({4{64'h5555_5555_5555_5555}});
    offer_tick({4{64'hAAAA_AAAA_AAAA_AAAA}});
    repeat (10) offer_tick(random_bits());
    offer_read(8'd0);
    offer_read(8'd127);
    offer_read(8'd255);
  endtask

  // Constant sparks push the levels into saturation, then a spark-free stretch
  // lets the heat die away and the drive run down to its floor.
  task automatic test_flood_and_drain();
    for (int n = 0; n < FLOOD_TICKS; n++) begin
      offer_tick('1);
      if (n % 4 == 0) begin
        offer_read(PIX_W'($urandom_range(0, 255)));
      end
    end
    for (int n = 0; n < DRAIN_TICKS; n++) begin
      offer_tick('0);
      if (n % 4 == 0) begin
        offer_read(PIX_W'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic test_output_hold_off();
    sender_idle_max = 0;
    hold_request = 1'b1;
    repeat (40) offer_read(PIX_W'($urandom_range(0, 255)));
    offer_tick(draw_sparks(SPARK_RANDOM));
    repeat (10) offer_read(PIX_W'($urandom_range(0, 255)));
    sender_idle_max = IDLE_MAX;
  endtask

  task automatic test_random_mix();
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) begin
        case ($urandom_range(0, 3))
          0: begin
            sender_idle_max = IDLE_MAX;
            receiver_idle_max = IDLE_MAX;
          end
          1: begin
            sender_idle_max = 0;
            receiver_idle_max = IDLE_MAX;
          end
          2: begin
            sender_idle_max = IDLE_MAX;
            receiver_idle_max = 0;
          end
          default: begin
            sender_idle_max = 0;
            receiver_idle_max = 0;
          end
        endcase
      end
      if ($urandom_range(0, 3) == 0) begin
        offer_tick(draw_sparks(spark_mix_e'($urandom_range(0, 4))));
      end else begin
        offer_read(PIX_W'($urandom_range(0, 255)));
      end
    end
    sender_idle_max = IDLE_MAX;
    receiver_idle_max = IDLE_MAX;
  endtask

  initial begin : receiver
    int unsigned gap;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        out_bus.ready = 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk_i);
        hold_request = 1'b0;
        hold_offs++;
      end
      gap = $urandom_range(0, receiver_idle_max);
      if (gap != 0) begin
        out_bus.ready = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_bus.ready = 1'b1;
      do @(posedge clk_i); while (!out_bus.valid);
    end
  end

  always @(posedge clk_i) begin
    pixel_rgb_t want;
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (pending_colors.size() == 0) begin
        stray_results++;
        if (stray_results + mismatches <= REPORT_MAX) begin
          $display("Unexpected color at %0t: red %0d green %0d blue %0d", $realtime,
                   out_bus.red, out_bus.green, out_bus.blue);
        end
      end else begin
        want = pending_colors.pop_front();
        colors_checked++;
        if (out_bus.red !== want.red || out_bus.green !== want.green ||
            out_bus.blue !== want.blue) begin
          mismatches++;
          if (stray_results + mismatches <= REPORT_MAX) begin
            $display("Color mismatch at %0t: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                     $realtime, want.red, want.green, want.blue,
                     out_bus.red, out_bus.green, out_bus.blue);
          end
        end
      end
    end
  end

  initial begin : watchdog
    do @(posedge clk_i); while (quiet_cycles < STALL_LIMIT);
    $display("Timeout after %0d cycles without an item moving.", quiet_cycles);
    $display("water_ripple_texture_animator_test: FAIL");
    $finish;
  end

  initial begin
    in_bus.valid = 1'b0;
    in_bus.command = CMD_TICK;
    in_bus.spark_bits_0 = '0;
    in_bus.spark_bits_1 = '0;
    in_bus.spark_bits_2 = '0;
    in_bus.spark_bits_3 = '0;
    in_bus.pixel_index = '0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed_corners();
    test_flood_and_drain();
    test_output_hold_off();
    test_random_mix();
    in_bus.valid = 1'b0;
    while (pending_colors.size() != 0) @(posedge clk_i);
    repeat (END_SETTLE) @(posedge clk_i);
    failures = mismatches + stray_results + pending_colors.size();
    $display("Ran %0d ticks (%0d frame counter wraps) and %0d pixel reads; %0d colors checked.",
             ticks_sent, frame_wraps, reads_sent, colors_checked);
    $display("Level ceiling reached: %0d, drive floor reached: %0d, output hold-offs: %0d.",
             level_ceiling_seen, drive_floor_seen, hold_offs);
    if (failures == 0) begin
      $display("water_ripple_texture_animator_test: PASS");
    end else begin
      $display("water_ripple_texture_animator_test: FAIL");
    end
    $finish;
  end

endmodule

// ===== water_ripple_texture_animator.f =====
hdl/wra_pkg.sv
hdl/wra_in_if.sv
hdl/wra_out_if.sv
hdl/wra_fdiv5.sv
hdl/wra_store.sv
hdl/wra_update.sv
hdl/water_ripple_texture_animator.sv
test/water_ripple_texture_animator_test.sv
